@@ hdl/seirs_pkg.sv @@
`timescale 1ns / 1ps

package seirs_pkg;

    localparam int MAX_VERTICES = 1024;
    localparam int EDGE_SLOTS   = 4096;
    localparam int MAX_DEGREE   = 255;

    localparam int VW   = $clog2(MAX_VERTICES);
    localparam int EW   = $clog2(EDGE_SLOTS);
    localparam int DW   = 8;
    localparam int CNTW = VW + 1;

    localparam logic [2:0] FUNC_WR_VERTEX = 3'd0;
    localparam logic [2:0] FUNC_WR_RANGE  = 3'd1;
    localparam logic [2:0] FUNC_WR_EDGE   = 3'd2;
    localparam logic [2:0] FUNC_DAY_STEP  = 3'd3;
    localparam logic [2:0] FUNC_RD_VERTEX = 3'd4;

    localparam logic [1:0] CL_S = 2'd0;
    localparam logic [1:0] CL_L = 2'd1;
    localparam logic [1:0] CL_I = 2'd2;
    localparam logic [1:0] CL_R = 2'd3;

    localparam logic [2:0] REG_DAYS_LATENT     = 3'd0;
    localparam logic [2:0] REG_DAYS_INFECTIOUS = 3'd1;
    localparam logic [2:0] REG_DAYS_RECOVERED  = 3'd2;
    localparam logic [2:0] REG_R0              = 3'd3;
    localparam logic [2:0] REG_SEED            = 3'd4;
    localparam logic [2:0] REG_VERTEX_COUNT    = 3'd5;

    typedef struct packed {
        logic [2:0]    func;
        logic [VW-1:0] vertex;
        logic [1:0]    class_in;
        logic [EW-1:0] edge_base;
        logic [DW-1:0] degree;
        logic [EW-1:0] edge_slot;
        logic [VW-1:0] neighbor;
    } in_word_t;

    typedef struct packed {
        logic            status;
        logic [1:0]      class_out;
        logic [7:0]      counter_out;
        logic [CNTW-1:0] count_susceptible;
        logic [CNTW-1:0] count_latent;
        logic [CNTW-1:0] count_infectious;
        logic [CNTW-1:0] count_recovered;
    } out_word_t;

    typedef enum logic [4:0] {
        S_IDLE, S_HOST, S_COPY_RD, S_COPY_WR, S_V_CHECK, S_V_RD, S_V_EVAL,
        S_V_NEXT, S_E_BEGIN, S_E_RD, S_E_CHK, S_E_NRD, S_E_TEST, S_E_DRAW,
        S_E_MUL, S_E_CMP, S_E_NEXT, S_INC_START, S_INC_CHECK, S_INC_RD,
        S_INC_WR, S_FLIP, S_RESULT
    } ctl_state_t;

    typedef enum logic [4:0] {
        DP_NONE, DP_LATCH, DP_HOST, DP_COPY_RD, DP_COPY_WR, DP_V_RD, DP_V_EVAL,
        DP_V_NEXT, DP_E_RD, DP_E_NRD, DP_E_DRAW, DP_E_MUL, DP_E_CMP, DP_E_NEXT,
        DP_INC_START, DP_INC_RD, DP_INC_WR, DP_FLIP, DP_RESULT
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } ctl_cmd_t;

    typedef struct packed {
        logic day_ok;
        logic copy_last;
        logic sweep_end;
        logic spread;
        logic edge_done;
        logic nv_skip;
        logic nv_susc;
    } dp_status_t;

endpackage

@@ hdl/seirs_dp.sv @@
`timescale 1ns / 1ps

module seirs_dp (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_write,
    input  logic [2:0]          cfg_index,
    input  logic [31:0]         cfg_data,
    input  seirs_pkg::in_word_t in_word,
    input  seirs_pkg::ctl_cmd_t cmd,
    output seirs_pkg::dp_status_t status,
    output seirs_pkg::out_word_t  out_word
);
    import seirs_pkg::*;

    logic [DW+1:0]      vmem [2*MAX_VERTICES];
    logic [EW+DW-1:0]   bmem [MAX_VERTICES];
    logic [VW-1:0]      emem [EDGE_SLOTS];

    in_word_t           item_reg;
    out_word_t          res_reg;
    logic               bank_reg;
    logic [CNTW-1:0]    idx_reg;
    logic [DW-1:0]      k_reg;
    logic [DW+1:0]      vrd_reg;
    logic [EW+DW-1:0]   brd_reg;
    logic [VW-1:0]      erd_reg;
    logic [31:0]        gen_reg;
    logic [23:0]        p1_reg;
    logic [31:0]        p2_reg;
    logic [CNTW-1:0]    cnt_reg [4];
    logic [7:0]         dl_reg;
    logic [7:0]         di_reg;
    logic [7:0]         dr_reg;
    logic [15:0]        r0_reg;
    logic [CNTW-1:0]    vcount_reg;

    logic               bad;
    logic [EW:0]        range_end;
    logic [EW:0]        slot;
    logic [31:0]        g1;
    logic [31:0]        g2;
    logic [31:0]        gen_next;
    logic [1:0]         vcls;
    logic [7:0]         vcnt;
    logic               trans;
    logic [1:0]         trans_cls;
    logic               hit;
    logic [VW:0]        vra;
    logic [VW:0]        vwa;
    logic [DW+1:0]      vwd;
    logic               v_ren;
    logic               v_we;
    logic [EW-1:0]      ebase;
    logic [DW-1:0]      edeg;

    assign ebase     = brd_reg[EW+DW-1:DW];
    assign edeg      = brd_reg[DW-1:0];
    assign range_end = {1'b0, item_reg.edge_base} + {{(EW+1-DW){1'b0}}, item_reg.degree};
    assign slot      = {1'b0, ebase} + {{(EW+1-DW){1'b0}}, k_reg};
    assign vcls      = vrd_reg[DW+1:DW];
    assign vcnt      = vrd_reg[DW-1:0];
    assign g1        = gen_reg ^ (gen_reg << 13);
    assign g2        = g1 ^ (g1 >> 17);
    assign gen_next  = g2 ^ (g2 << 5);
    assign hit       = p2_reg < {8'h00, r0_reg, 8'h00};

    always_comb
    begin
        case (item_reg.func)
            FUNC_WR_VERTEX, FUNC_RD_VERTEX:
                bad = ({1'b0, item_reg.vertex} >= (VW+1)'(MAX_VERTICES));
            FUNC_WR_RANGE:
                bad = ({1'b0, item_reg.vertex} >= (VW+1)'(MAX_VERTICES))
                    || ({1'b0, item_reg.degree} > (DW+1)'(MAX_DEGREE))
                    || (range_end > (EW+1)'(EDGE_SLOTS));
            FUNC_WR_EDGE:
                bad = ({1'b0, item_reg.edge_slot} >= (EW+1)'(EDGE_SLOTS))
                    || ({1'b0, item_reg.neighbor} >= (VW+1)'(MAX_VERTICES));
            FUNC_DAY_STEP:
                bad = (vcount_reg > CNTW'(MAX_VERTICES));
            default:
                bad = 1'b1;
        endcase
    end

    always_comb
    begin
        trans     = 1'b0;
        trans_cls = CL_S;
        case (vcls)
            CL_L:
            begin
                trans     = (vcnt == dl_reg);
                trans_cls = CL_I;
            end
            CL_I:
            begin
                trans     = (vcnt == di_reg);
                trans_cls = CL_R;
            end
            CL_R:
            begin
                trans     = (vcnt == dr_reg);
                trans_cls = CL_S;
            end
            default:
            begin
                trans     = 1'b0;
                trans_cls = CL_S;
            end
        endcase
    end

    always_comb
    begin
        status.day_ok    = (item_reg.func == FUNC_DAY_STEP) && !bad;
        status.copy_last = (idx_reg[VW-1:0] == {VW{1'b1}});
        status.sweep_end = (idx_reg == vcount_reg);
        status.spread    = (vcls == CL_I) && (vcnt != di_reg);
        status.edge_done = (k_reg >= edeg) || (slot >= (EW+1)'(EDGE_SLOTS));
        status.nv_skip   = ({1'b0, erd_reg} >= vcount_reg);
        status.nv_susc   = (vcls == CL_S);
    end

    always_comb
    begin
        vra   = {bank_reg, idx_reg[VW-1:0]};
        vwa   = {!bank_reg, idx_reg[VW-1:0]};
        vwd   = vrd_reg;
        v_ren = 1'b0;
        v_we  = 1'b0;
        case (cmd.op)
            DP_HOST:
            begin
                vra   = {bank_reg, item_reg.vertex};
                vwa   = {bank_reg, item_reg.vertex};
                vwd   = {item_reg.class_in, 8'h00};
                v_ren = (item_reg.func == FUNC_RD_VERTEX);
                v_we  = (item_reg.func == FUNC_WR_VERTEX) && !bad;
            end
            DP_COPY_RD, DP_V_RD:
                v_ren = 1'b1;
            DP_COPY_WR:
                v_we = 1'b1;
            DP_V_EVAL:
            begin
                v_we = trans;
                vwd  = {trans_cls, 8'h00};
            end
            DP_E_NRD:
            begin
                vra   = {bank_reg, erd_reg};
                v_ren = 1'b1;
            end
            DP_E_CMP:
            begin
                vwa  = {!bank_reg, erd_reg};
                vwd  = {CL_L, 8'h00};
                v_we = hit;
            end
            DP_INC_RD:
            begin
                vra   = {!bank_reg, idx_reg[VW-1:0]};
                v_ren = 1'b1;
            end
            DP_INC_WR:
            begin
                v_we = 1'b1;
                vwd  = {vcls, (vcnt == 8'hFF) ? vcnt : vcnt + 8'd1};
            end
            default:
            begin
                v_ren = 1'b0;
                v_we  = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (v_we)
            vmem[vwa] <= vwd;
        if (v_ren)
            vrd_reg <= vmem[vra];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == DP_HOST && item_reg.func == FUNC_WR_RANGE && !bad)
            bmem[item_reg.vertex] <= {item_reg.edge_base, item_reg.degree};
        if (cmd.op == DP_V_RD)
            brd_reg <= bmem[idx_reg[VW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == DP_HOST && item_reg.func == FUNC_WR_EDGE && !bad)
            emem[item_reg.edge_slot] <= item_reg.neighbor;
        if (cmd.op == DP_E_RD)
            erd_reg <= emem[slot[EW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == DP_LATCH)
            item_reg <= in_word;
        if (cmd.op == DP_E_DRAW)
            p1_reg <= {8'h00, gen_next[31:16]} * {16'h0000, edeg};
        if (cmd.op == DP_E_MUL)
            p2_reg <= {8'h00, p1_reg} * {24'h0, di_reg};
        if (cmd.op == DP_RESULT)
        begin
            res_reg                   <= '0;
            res_reg.status            <= bad;
            if (item_reg.func == FUNC_RD_VERTEX && !bad)
            begin
                res_reg.class_out   <= vcls;
                res_reg.counter_out <= vcnt;
            end
            if (item_reg.func == FUNC_DAY_STEP && !bad)
            begin
                res_reg.count_susceptible <= cnt_reg[CL_S];
                res_reg.count_latent      <= cnt_reg[CL_L];
                res_reg.count_infectious  <= cnt_reg[CL_I];
                res_reg.count_recovered   <= cnt_reg[CL_R];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bank_reg   <= 1'b0;
            idx_reg    <= '0;
            k_reg      <= '0;
            gen_reg    <= 32'd1;
            dl_reg     <= 8'd1;
            di_reg     <= 8'd3;
            dr_reg     <= 8'd56;
            r0_reg     <= 16'd512;
            vcount_reg <= CNTW'(1000);
            for (int c = 0; c < 4; c++)
                cnt_reg[c] <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_DAYS_LATENT:     dl_reg <= cfg_data[7:0];
                    REG_DAYS_INFECTIOUS: di_reg <= cfg_data[7:0];
                    REG_DAYS_RECOVERED:  dr_reg <= cfg_data[7:0];
                    REG_R0:              r0_reg <= cfg_data[15:0];
                    REG_SEED:            gen_reg <= (cfg_data == 32'd0) ? 32'd1 : cfg_data;
                    REG_VERTEX_COUNT:    vcount_reg <= cfg_data[CNTW-1:0];
                    default:             ;
                endcase
            end
            case (cmd.op)
                DP_HOST:
                    idx_reg <= '0;
                DP_COPY_WR:
                    idx_reg <= status.copy_last ? '0 : idx_reg + 1'b1;
                DP_V_NEXT:
                    idx_reg <= idx_reg + 1'b1;
                DP_V_EVAL:
                    k_reg <= '0;
                DP_E_NEXT:
                    k_reg <= k_reg + 1'b1;
                DP_E_DRAW:
                    gen_reg <= gen_next;
                DP_INC_START:
                begin
                    idx_reg <= '0;
                    for (int c = 0; c < 4; c++)
                        cnt_reg[c] <= '0;
                end
                DP_INC_WR:
                begin
                    idx_reg       <= idx_reg + 1'b1;
                    cnt_reg[vcls] <= cnt_reg[vcls] + 1'b1;
                end
                DP_FLIP:
                    bank_reg <= !bank_reg;
                default:
                    ;
            endcase
        end
    end

    assign out_word = res_reg;

endmodule

@@ hdl/seirs_ctl.sv @@
`timescale 1ns / 1ps

module seirs_ctl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    output logic                   out_valid,
    input  logic                   out_stall,
    input  seirs_pkg::dp_status_t  status,
    output seirs_pkg::ctl_cmd_t    cmd,
    output seirs_pkg::ctl_state_t  state
);
    import seirs_pkg::*;

    ctl_state_t state_reg;
    ctl_state_t state_next;
    logic       out_valid_reg;
    logic       out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cmd.op         = DP_NONE;
        out_valid_next = out_valid_reg && out_stall;
        case (state_reg)
            S_IDLE:
                if (in_valid)
                begin
                    cmd.op     = DP_LATCH;
                    state_next = S_HOST;
                end
            S_HOST:
            begin
                cmd.op     = DP_HOST;
                state_next = status.day_ok ? S_COPY_RD : S_RESULT;
            end
            S_COPY_RD:
            begin
                cmd.op     = DP_COPY_RD;
                state_next = S_COPY_WR;
            end
            S_COPY_WR:
            begin
                cmd.op     = DP_COPY_WR;
                state_next = status.copy_last ? S_V_CHECK : S_COPY_RD;
            end
            S_V_CHECK:
                state_next = status.sweep_end ? S_INC_START : S_V_RD;
            S_V_RD:
            begin
                cmd.op     = DP_V_RD;
                state_next = S_V_EVAL;
            end
            S_V_EVAL:
            begin
                cmd.op     = DP_V_EVAL;
                state_next = status.spread ? S_E_BEGIN : S_V_NEXT;
            end
            S_V_NEXT:
            begin
                cmd.op     = DP_V_NEXT;
                state_next = S_V_CHECK;
            end
            S_E_BEGIN:
                state_next = status.edge_done ? S_V_NEXT : S_E_RD;
            S_E_RD:
            begin
                cmd.op     = DP_E_RD;
                state_next = S_E_CHK;
            end
            S_E_CHK:
                state_next = status.nv_skip ? S_E_NEXT : S_E_NRD;
            S_E_NRD:
            begin
                cmd.op     = DP_E_NRD;
                state_next = S_E_TEST;
            end
            S_E_TEST:
                state_next = status.nv_susc ? S_E_DRAW : S_E_NEXT;
            S_E_DRAW:
            begin
                cmd.op     = DP_E_DRAW;
                state_next = S_E_MUL;
            end
            S_E_MUL:
            begin
                cmd.op     = DP_E_MUL;
                state_next = S_E_CMP;
            end
            S_E_CMP:
            begin
                cmd.op     = DP_E_CMP;
                state_next = S_E_NEXT;
            end
            S_E_NEXT:
            begin
                cmd.op     = DP_E_NEXT;
                state_next = S_E_BEGIN;
            end
            S_INC_START:
            begin
                cmd.op     = DP_INC_START;
                state_next = S_INC_CHECK;
            end
            S_INC_CHECK:
                state_next = status.sweep_end ? S_FLIP : S_INC_RD;
            S_INC_RD:
            begin
                cmd.op     = DP_INC_RD;
                state_next = S_INC_WR;
            end
            S_INC_WR:
            begin
                cmd.op     = DP_INC_WR;
                state_next = S_INC_CHECK;
            end
            S_FLIP:
            begin
                cmd.op     = DP_FLIP;
                state_next = S_RESULT;
            end
            S_RESULT:
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.op         = DP_RESULT;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            default:
                state_next = S_IDLE;
        endcase
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign state     = state_reg;

endmodule

@@ hdl/seirs_network_day_step.sv @@
`timescale 1ns / 1ps
// Host writes, vertex reads and rejected words pass through the host and result states
// after acceptance; no new word is taken until the previous result has been issued.
// A day step copies the current bank into the other, sweeps vertex_count vertices, lets
// each spreading infectious vertex scan its neighbour slots and draw for susceptible
// neighbours inside the sweep, then ages and counts the classes and flips the bank.
// Reset clears control state and sets configuration to defaults; graph tables are undefined until written.

module seirs_network_day_step (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  seirs_pkg::in_word_t  in_word,
    output logic                 out_valid,
    input  logic                 out_stall,
    output seirs_pkg::out_word_t out_word,
    input  logic                 cfg_write,
    input  logic [2:0]           cfg_index,
    input  logic [31:0]          cfg_data
);
    import seirs_pkg::*;

    ctl_cmd_t   cmd;
    dp_status_t status;
    ctl_state_t state;

    seirs_ctl u_ctl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd),
        .state     (state)
    );

    seirs_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_word   (in_word),
        .cmd       (cmd),
        .status    (status),
        .out_word  (out_word)
    );

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("Block took a word without going busy.");

    a_result_from_state: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state == S_RESULT))
        else $error("Result raised outside the result state.");

    a_draw_then_mul: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == DP_E_DRAW) |=> (cmd.op == DP_E_MUL))
        else $error("Draw not followed by the second multiply.");

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
    import seirs_pkg::*;

    localparam int WATCH_LIMIT = 20000;
    localparam int GRAPH_V     = 8;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    in_word_t   in_word = '0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    out_word_t  out_word;
    logic       cfg_write = 1'b0;
    logic [2:0] cfg_index = '0;
    logic [31:0] cfg_data = '0;

    seirs_network_day_step dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
        .out_valid(out_valid), .out_stall(out_stall), .out_word(out_word),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // Mirror of the graph, the two state banks and the configuration registers.
    logic [1:0]  class_mem [2*MAX_VERTICES];
    logic [7:0]  days_mem [2*MAX_VERTICES];
    logic [11:0] base_mem [MAX_VERTICES];
    logic [7:0]  deg_mem [MAX_VERTICES];
    logic [9:0]  edge_mem [EDGE_SLOTS];
    bit          bank_sel;
    logic [31:0] gen_state = 32'd1;
    logic [7:0]  dur_latent = 8'd1, dur_infectious = 8'd3, dur_recovered = 8'd56;
    logic [15:0] r0_fix = 16'd512;
    logic [10:0] sweep_count = 11'd1000;

    in_word_t  pending_words[$];
    out_word_t expected_words[$];
    int        error_count = 0;
    int        idle_cycles = 0;
    bit        no_gaps = 1'b0;
    int        send_gap = 0;
    int        stall_left = 0;

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic logic [15:0] next_draw();
        logic [31:0] x;
        x = gen_state;
        x = x ^ (x << 13);
        x = x ^ (x >> 17);
        x = x ^ (x << 5);
        gen_state = x;
        return x[31:16];
    endfunction

    function automatic void run_day(inout out_word_t r);
        int ob, nb, n, slot, nv, deg;
        int counts [4];
        logic [1:0] c;
        logic [7:0] t;
        longint d, lim;
        ob = bank_sel ? MAX_VERTICES : 0;
        nb = bank_sel ? 0 : MAX_VERTICES;
        n = sweep_count;
        lim = longint'(r0_fix) * 256;
        counts = '{0, 0, 0, 0};
        for (int i = 0; i < MAX_VERTICES; i++)
        begin
            class_mem[nb+i] = class_mem[ob+i];
            days_mem[nb+i] = days_mem[ob+i];
        end
        for (int i = 0; i < n; i++)
        begin
            c = class_mem[ob+i];
            t = days_mem[ob+i];
            if (c == CL_L && t == dur_latent)
            begin
                class_mem[nb+i] = CL_I;
                days_mem[nb+i] = '0;
            end
            else if (c == CL_I && t == dur_infectious)
            begin
                class_mem[nb+i] = CL_R;
                days_mem[nb+i] = '0;
            end
            else if (c == CL_I)
            begin
                deg = deg_mem[i];
                for (int k = 0; k < deg; k++)
                begin
                    slot = base_mem[i] + k;
                    if (slot >= EDGE_SLOTS)
                        break;
                    nv = edge_mem[slot];
                    if (nv < n && class_mem[ob+nv] == CL_S)
                    begin
                        d = next_draw();
                        if (d * deg * dur_infectious < lim)
                        begin
                            class_mem[nb+nv] = CL_L;
                            days_mem[nb+nv] = '0;
                        end
                    end
                end
            end
            else if (c == CL_R && t == dur_recovered)
            begin
                class_mem[nb+i] = CL_S;
                days_mem[nb+i] = '0;
            end
        end
        for (int i = 0; i < n; i++)
        begin
            if (days_mem[nb+i] != 8'd255)
                days_mem[nb+i]++;
            counts[class_mem[nb+i]]++;
        end
        bank_sel = ~bank_sel;
        r.count_susceptible = CNTW'(counts[0]);
        r.count_latent = CNTW'(counts[1]);
        r.count_infectious = CNTW'(counts[2]);
        r.count_recovered = CNTW'(counts[3]);
    endfunction

    function automatic void predict_word(in_word_t w);
        out_word_t r;
        int cur;
        r = '0;
        cur = bank_sel ? MAX_VERTICES : 0;
        case (w.func)
            FUNC_WR_VERTEX:
            begin
                class_mem[cur+w.vertex] = w.class_in;
                days_mem[cur+w.vertex] = '0;
            end
            FUNC_WR_RANGE:
            begin
                if (int'(w.edge_base) + int'(w.degree) > EDGE_SLOTS
                        || w.degree > MAX_DEGREE)
                    r.status = 1'b1;
                else
                begin
                    base_mem[w.vertex] = w.edge_base;
                    deg_mem[w.vertex] = w.degree;
                end
            end
            FUNC_WR_EDGE: edge_mem[w.edge_slot] = w.neighbor;
            FUNC_DAY_STEP:
            begin
                if (sweep_count > MAX_VERTICES)
                    r.status = 1'b1;
                else
                    run_day(r);
            end
            FUNC_RD_VERTEX:
            begin
                r.class_out = class_mem[cur+w.vertex];
                r.counter_out = days_mem[cur+w.vertex];
            end
            default: r.status = 1'b1;
        endcase
        expected_words.push_back(r);
    endfunction

    task automatic report(input string what, input int got, input int want);
        $display("mismatch on %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_word <= '0;
            send_gap = 0;
        end
        else
        begin
            bit holding;
            holding = in_valid;
            if (in_valid && !in_stall)
            begin
                predict_word(in_word);
                holding = 1'b0;
                send_gap = no_gaps ? 0 : $urandom_range(0, 19);
            end
            if (!holding)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    in_valid <= 1'b0;
                end
                else if (pending_words.size() > 0)
                begin
                    in_word <= pending_words.pop_front();
                    in_valid <= 1'b1;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                out_word_t e;
                if (expected_words.size() == 0)
                begin
                    report("unexpected word", 1, 0);
                end
                else
                begin
                    e = expected_words.pop_front();
                    if (out_word.status !== e.status)
                        report("status", out_word.status, e.status);
                    if (out_word.class_out !== e.class_out)
                        report("class_out", out_word.class_out, e.class_out);
                    if (out_word.counter_out !== e.counter_out)
                        report("counter_out", out_word.counter_out, e.counter_out);
                    if (out_word.count_susceptible !== e.count_susceptible)
                        report("count_susceptible", out_word.count_susceptible,
                               e.count_susceptible);
                    if (out_word.count_latent !== e.count_latent)
                        report("count_latent", out_word.count_latent, e.count_latent);
                    if (out_word.count_infectious !== e.count_infectious)
                        report("count_infectious", out_word.count_infectious,
                               e.count_infectious);
                    if (out_word.count_recovered !== e.count_recovered)
                        report("count_recovered", out_word.count_recovered,
                               e.count_recovered);
                end
                stall_left = no_gaps ? 0 : $urandom_range(0, 19);
            end
            if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_write)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCH_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic set_reg(input logic [2:0] idx, input logic [31:0] val);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        case (idx)
            REG_DAYS_LATENT:     dur_latent = val[7:0];
            REG_DAYS_INFECTIOUS: dur_infectious = val[7:0];
            REG_DAYS_RECOVERED:  dur_recovered = val[7:0];
            REG_R0:              r0_fix = val[15:0];
            REG_SEED:            gen_state = (val == 0) ? 32'd1 : val;
            REG_VERTEX_COUNT:    sweep_count = val[10:0];
            default: ;
        endcase
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic wait_idle();
        do
            @(posedge clk);
        while (pending_words.size() != 0 || in_valid || expected_words.size() != 0);
        repeat (8) @(posedge clk);
    endtask

    function automatic in_word_t noise_word(logic [2:0] f);
        logic [63:0] bits;
        in_word_t w;
        bits = {$urandom(), $urandom()};
        w = bits[$bits(in_word_t)-1:0];
        w.func = f;
        return w;
    endfunction

    function automatic in_word_t range_word(int v, int b, int d);
        in_word_t w;
        w = noise_word(FUNC_WR_RANGE);
        w.vertex = VW'(v);
        w.edge_base = EW'(b);
        w.degree = DW'(d);
        return w;
    endfunction

    function automatic in_word_t edge_word(int s, int nv);
        in_word_t w;
        w = noise_word(FUNC_WR_EDGE);
        w.edge_slot = EW'(s);
        w.neighbor = VW'(nv);
        return w;
    endfunction

    function automatic in_word_t vertex_word(logic [2:0] f, int v, int c);
        in_word_t w;
        w = noise_word(f);
        w.vertex = VW'(v);
        w.class_in = 2'(c);
        return w;
    endfunction

    function automatic in_word_t random_word();
        int pick;
        int d;
        pick = $urandom_range(0, 99);
        if (pick < 25)
            return vertex_word(FUNC_WR_VERTEX, $urandom_range(0, 1023), $urandom_range(0, 3));
        if (pick < 35)
        begin
            if ($urandom_range(0, 4) == 0)
            begin
                d = $urandom_range(2, 255);
                return range_word($urandom_range(0, 1023), $urandom_range(4097 - d, 4095), d);
            end
            d = $urandom_range(0, 2);
            return range_word($urandom_range(0, 1023), $urandom_range(0, 2 * GRAPH_V - d), d);
        end
        if (pick < 55)
            return edge_word(($urandom_range(0, 1) == 0) ? $urandom_range(0, 2 * GRAPH_V - 1)
                             : $urandom_range(0, 4095),
                             ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023)
                             : $urandom_range(0, GRAPH_V + 2));
        if (pick < 70)
            return noise_word(FUNC_DAY_STEP);
        if (pick < 95)
            return vertex_word(FUNC_RD_VERTEX, $urandom_range(0, GRAPH_V - 1), 0);
        return noise_word(3'($urandom_range(5, 7)));
    endfunction

    initial
    begin
        logic [31:0] settings [6];
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        no_gaps = 1'b1;
        for (int v = 0; v < GRAPH_V; v++)
        begin
            pending_words.push_back(vertex_word(FUNC_WR_VERTEX, v, $urandom_range(0, 3)));
            pending_words.push_back(range_word(v, 2 * v, $urandom_range(0, 2)));
        end
        for (int s = 0; s < 2 * GRAPH_V; s++)
            pending_words.push_back(edge_word(s, ($urandom_range(0, 3) == 0)
                                    ? $urandom_range(0, 1023)
                                    : $urandom_range(0, GRAPH_V + 2)));
        wait_idle();

        for (int phase = 0; phase < 8; phase++)
        begin
            no_gaps = (phase == 5);
            case (phase)
                0: settings = '{1, 3, 56, 512, 1, GRAPH_V};
                1: settings = '{0, 0, 0, 65535, 0, 0};
                2: settings = '{255, 255, 255, 0, 32'hFFFF_FFFF, GRAPH_V};
                3: settings = '{1, 2, 3, 512, $urandom(), 1025};
                4: settings = '{1, 1, 1, 65535, $urandom(), 2047};
                default: settings = '{$urandom_range(1, 6), $urandom_range(1, 6),
                                      $urandom_range(1, 6), $urandom_range(0, 65535),
                                      $urandom(), $urandom_range(1, GRAPH_V)};
            endcase
            for (int r = 0; r < 6; r++)
                set_reg(3'(r), settings[r]);

            if (phase == 2)
            begin
                for (int v = 0; v < 4; v++)
                    pending_words.push_back(vertex_word(FUNC_WR_VERTEX, v, v));
                pending_words.push_back(vertex_word(FUNC_WR_VERTEX, 1023, CL_I));
                pending_words.push_back(range_word(2, 0, 3));
                pending_words.push_back(range_word(1023, 4093, 3));
                pending_words.push_back(range_word(5, 4095, 2));
                pending_words.push_back(range_word(6, 3900, 255));
                pending_words.push_back(range_word(7, 100, 0));
                pending_words.push_back(edge_word(0, 0));
                pending_words.push_back(edge_word(1, 1));
                pending_words.push_back(edge_word(2, 1023));
                pending_words.push_back(edge_word(4095, 1023));
                for (int f = 5; f < 8; f++)
                    pending_words.push_back(noise_word(3'(f)));
                pending_words.push_back(noise_word(FUNC_DAY_STEP));
                for (int v = 0; v < 4; v++)
                    pending_words.push_back(vertex_word(FUNC_RD_VERTEX, v, 0));
                pending_words.push_back(vertex_word(FUNC_RD_VERTEX, 1023, 0));
            end

            pending_words.push_back(noise_word(FUNC_DAY_STEP));
            for (int k = 0; k < 4; k++)
                pending_words.push_back(random_word());
            pending_words.push_back(noise_word(FUNC_DAY_STEP));
            wait_idle();
        end

        repeat (20) @(posedge clk);
        if (error_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

@@ sim.f @@
hdl/seirs_pkg.sv
hdl/seirs_dp.sv
hdl/seirs_ctl.sv
hdl/seirs_network_day_step.sv
verif/tb_top.sv
